// ===== src/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int RAM_BANK_AW = 13;
  localparam int ROM_OFF_W   = 14;
  localparam int ROM_ADDR_W  = 21;
  localparam int RTC_REGS    = 5;
  localparam int RTC_IDX_W   = 3;

  localparam logic [RTC_IDX_W-1:0] RTC_SEC   = 3'd0;
  localparam logic [RTC_IDX_W-1:0] RTC_MIN   = 3'd1;
  localparam logic [RTC_IDX_W-1:0] RTC_HOUR  = 3'd2;
  localparam logic [RTC_IDX_W-1:0] RTC_DAYLO = 3'd3;
  localparam logic [RTC_IDX_W-1:0] RTC_DAYHI = 3'd4;

  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_RAM_BANK = 3'd2;
  localparam logic [2:0] RGN_LATCH    = 3'd3;
  localparam logic [2:0] RGN_EXT      = 3'd5;

  localparam logic CFG_RAM_PRESENT = 1'b0;
  localparam logic CFG_BANK_MASK   = 1'b1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [7:0] BYTE_NONE = 8'hFF;

  typedef struct packed {
    logic                 we;
    logic                 latch;
    logic [RTC_IDX_W-1:0] idx;
    logic [7:0]           wdata;
  } rtc_ctl_t;

endpackage

// ===== src/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// cbc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cbc_rtc.sv =====
// ----------------------------------------------------------------------------
// cbc_rtc
// Live and latched clock register bytes: range-reduced writes, latch copy,
// latched read-back.
// ----------------------------------------------------------------------------
module cbc_rtc
  import cbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtc_ctl_t             ctl,
  input  logic [RTC_IDX_W-1:0] rd_idx,
  output logic [7:0]           rd_data
);

  logic [7:0] live_r    [RTC_REGS];
  logic [7:0] latched_r [RTC_REGS];
  logic [7:0] store_val;

  function automatic logic [7:0] mod60(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd240) t = t - 8'd240;
    if (t >= 8'd120) t = t - 8'd120;
    if (t >= 8'd60)  t = t - 8'd60;
    return t;
  endfunction

  function automatic logic [7:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd192) t = t - 8'd192;
    if (t >= 8'd96)  t = t - 8'd96;
    if (t >= 8'd48)  t = t - 8'd48;
    if (t >= 8'd24)  t = t - 8'd24;
    return t;
  endfunction

  always_comb begin
    case (ctl.idx)
      RTC_SEC, RTC_MIN: store_val = mod60(ctl.wdata);
      RTC_HOUR:         store_val = mod24(ctl.wdata);
      RTC_DAYLO:        store_val = ctl.wdata;
      default:          store_val = ctl.wdata & 8'hC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RTC_REGS; i++) begin
        live_r[i]    <= '0;
        latched_r[i] <= '0;
      end
    end else begin
      if (ctl.we && ctl.idx < RTC_IDX_W'(RTC_REGS)) begin
        live_r[ctl.idx] <= store_val;
      end
      if (ctl.latch) begin
        for (int i = 0; i < RTC_REGS; i++) begin
          latched_r[i] <= live_r[i];
        end
      end
    end
  end

  assign rd_data = (rd_idx < RTC_IDX_W'(RTC_REGS)) ? latched_r[rd_idx] : BYTE_NONE;

endmodule

// ===== src/cartridge_bank_controller.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Bank controller for a cartridge bus: control writes, ROM address mapping,
// banked external RAM and latched clock registers.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid/tready      tdata: command, address, write_data
//   out_     out  tvalid/tready      tdata: read_data, rom_select, rom_address
//   cfg_     in   wr_en              index, data
//
// One word per cycle sustained while the output is not stalled; a result passes
// through the pipeline register (with the external RAM read), then the output register.
// Control state is updated when the access is taken.
// After reset a clearing pass zeroes the external RAM, one entry a cycle, over
// all RAM_BANKS * 8192 entries; no access is taken until it ends.
// A stalled output holds the pipeline; in_tready drops when both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module cartridge_bank_controller
  import cbc_pkg::*;
#(
  parameter int RAM_BANKS     = 4,
  parameter int ROM_BANK_BITS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // command[0], address[16:1], write_data[24:17]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[7:0], rom_select[8], rom_address[29:9]
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  localparam int RAM_DEPTH = RAM_BANKS * (1 << RAM_BANK_AW);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  logic                     in_command;
  logic [15:0]              in_address;
  logic [7:0]               in_write_data;

  logic                     ram_present_r;
  logic [1:0]               bank_mask_r;
  logic [ROM_BANK_BITS-1:0] rom_bank_r, rom_bank_nxt;
  logic [1:0]               ram_bank_r, ram_bank_nxt;
  logic                     ram_en_r, ram_en_nxt;
  logic                     rtc_mode_r, rtc_mode_nxt;
  logic [RTC_IDX_W-1:0]     rtc_idx_r, rtc_idx_nxt;
  logic [7:0]               prev_latch_r, prev_latch_nxt;

  logic                     clear_r;
  logic [RAM_AW-1:0]        clr_addr_r;

  logic                     p_valid_r;
  logic                     p_src_ram_r;
  logic [7:0]               p_rd_r;
  logic                     p_rsel_r;
  logic [ROM_ADDR_W-1:0]    p_raddr_r;
  logic                     out_valid_r;
  logic [7:0]               out_rd_r;
  logic                     out_rsel_r;
  logic [ROM_ADDR_W-1:0]    out_raddr_r;

  logic                     adv;
  logic                     in_fire;
  logic                     ram_ok;
  logic [1:0]               eff_bank;
  logic [RAM_AW-1:0]        ram_addr;
  logic                     ext_we;
  logic                     ext_re;
  logic                     ram_we;
  logic [RAM_AW-1:0]        ram_waddr;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;
  logic [6:0]               rom_b7;
  rtc_ctl_t                 rtc_ctl;
  logic [7:0]               rtc_rdata;
  logic [7:0]               rd_val;
  logic                     rsel_val;
  logic [ROM_ADDR_W-1:0]    raddr_val;

  // wrap the masked bank into the number of fitted banks
  function automatic logic [1:0] bank_wrap(input logic [1:0] b);
    logic [2:0] t;
    t = {1'b0, b};
    for (int i = 0; i < 3; i++) begin
      if (t >= 3'(RAM_BANKS)) begin
        t = t - 3'(RAM_BANKS);
      end
    end
    return t[1:0];
  endfunction

  assign in_command    = in_tdata[0];
  assign in_address    = in_tdata[16:1];
  assign in_write_data = in_tdata[24:17];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !clear_r && (!p_valid_r || adv);
  assign in_fire   = in_tvalid && in_tready;

  assign ram_ok   = ram_en_r && ram_present_r;
  assign eff_bank = bank_wrap(ram_bank_r & bank_mask_r);
  assign ram_addr = RAM_AW'({eff_bank, in_address[RAM_BANK_AW-1:0]});
  assign rom_b7   = (in_write_data[6:0] == 7'd0) ? 7'd1 : in_write_data[6:0];

  // decode the access
  always_comb begin
    rom_bank_nxt   = rom_bank_r;
    ram_bank_nxt   = ram_bank_r;
    ram_en_nxt     = ram_en_r;
    rtc_mode_nxt   = rtc_mode_r;
    rtc_idx_nxt    = rtc_idx_r;
    prev_latch_nxt = prev_latch_r;
    ext_we         = 1'b0;
    ext_re         = 1'b0;
    rtc_ctl        = '0;
    rtc_ctl.idx    = rtc_idx_r;
    rtc_ctl.wdata  = in_write_data;
    rd_val         = BYTE_NONE;
    rsel_val       = 1'b0;
    raddr_val      = '0;
    if (in_command == CMD_WRITE) begin
      case (in_address[15:13])
        RGN_RAM_EN: begin
          ram_en_nxt = (in_write_data[3:0] == 4'hA);
        end
        RGN_ROM_BANK: begin
          rom_bank_nxt = rom_b7[ROM_BANK_BITS-1:0];
        end
        RGN_RAM_BANK: begin
          if (in_write_data <= 8'h03) begin
            ram_bank_nxt = in_write_data[1:0];
            rtc_mode_nxt = 1'b0;
          end else if (in_write_data inside {[8'h08:8'h0C]}) begin
            rtc_idx_nxt  = 3'(in_write_data - 8'h08);
            rtc_mode_nxt = 1'b1;
          end
        end
        RGN_LATCH: begin
          rtc_ctl.latch  = (prev_latch_r == 8'h00) && (in_write_data == 8'h01);
          prev_latch_nxt = in_write_data;
        end
        RGN_EXT: begin
          if (ram_ok) begin
            rtc_ctl.we = rtc_mode_r;
            ext_we     = !rtc_mode_r;
          end
        end
        default: begin
        end
      endcase
    end else if (!in_address[15]) begin
      rsel_val  = 1'b1;
      raddr_val = in_address[14] ? {7'(rom_bank_r), in_address[ROM_OFF_W-1:0]}
                                 : ROM_ADDR_W'(in_address);
    end else if (in_address[15:13] == RGN_EXT && ram_ok) begin
      if (rtc_mode_r) begin
        rd_val = rtc_rdata;
      end else begin
        ext_re = 1'b1;
      end
    end
    if (!in_fire) begin
      rtc_ctl.we    = 1'b0;
      rtc_ctl.latch = 1'b0;
      ext_we        = 1'b0;
      ext_re        = 1'b0;
    end
  end

  assign ram_we    = clear_r || ext_we;
  assign ram_waddr = clear_r ? clr_addr_r : ram_addr;
  assign ram_wdata = clear_r ? 8'h00 : in_write_data;

  cbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ext_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ext_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  cbc_rtc u_rtc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rtc_ctl),
    .rd_idx  (rtc_idx_r),
    .rd_data (rtc_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_present_r <= 1'b0;
      bank_mask_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RAM_PRESENT: ram_present_r <= cfg_data[0];
        CFG_BANK_MASK:   bank_mask_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r   <= ROM_BANK_BITS'(1);
      ram_bank_r   <= '0;
      ram_en_r     <= 1'b0;
      rtc_mode_r   <= 1'b0;
      rtc_idx_r    <= RTC_SEC;
      prev_latch_r <= '0;
    end else if (in_fire) begin
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      ram_en_r     <= ram_en_nxt;
      rtc_mode_r   <= rtc_mode_nxt;
      rtc_idx_r    <= rtc_idx_nxt;
      prev_latch_r <= prev_latch_nxt;
    end
  end

  // clearing pass over the external RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      clr_addr_r <= clr_addr_r + RAM_AW'(1);
      if (clr_addr_r == RAM_AW'(RAM_DEPTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_fire || (p_valid_r && !adv);
      if (adv) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_src_ram_r <= ext_re;
      p_rd_r      <= rd_val;
      p_rsel_r    <= rsel_val;
      p_raddr_r   <= raddr_val;
    end
    if (adv && p_valid_r) begin
      out_rd_r    <= p_src_ram_r ? ram_rdata : p_rd_r;
      out_rsel_r  <= p_rsel_r;
      out_raddr_r <= p_raddr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_raddr_r, out_rsel_r, out_rd_r};

`ifndef ASSERT_OFF
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_tready)
    else $error("access taken during RAM clearing pass");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && adv) |=> out_valid_r)
    else $error("pending word lost on advance");

  a_ram_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !clear_r) |-> in_fire)
    else $error("external RAM written without an access");

  a_rom_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsel_r) |-> (out_rd_r == BYTE_NONE))
    else $error("ROM read carries RAM data");
`endif

endmodule
